// File: sv/dbnc_pkg.sv
// ----------------------------------------------------------------------------
// dbnc_pkg
// shared constants and types of the multi-channel input debouncer
// ----------------------------------------------------------------------------
package dbnc_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned PINS         = 8;  // channels with a pin and a result slot
  localparam int unsigned CH_IDX_W     = 3;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READY_DELAY = 1'd1;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_W-1:0] READY_DELAY_RST = 16'd1000;

  typedef struct packed {
    logic chg;      // confirmed change on this item
    logic lvl_nxt;  // debounced level after this item
  } lane_res_t;

endpackage

// File: sv/multi_channel_input_debouncer_core.sv
// ----------------------------------------------------------------------------
// multi_channel_input_debouncer_core
// timestamp debouncer for up to eight reported input lines
//
//   port group   dir  contents
//   s_axis       in   tuser action, tdata now_ms [31:0], pin_levels [39:32]
//   m_axis       out  tuser changed, tdata channel/level/ready/levels, tlast
//   cfg          in   we, idx (0 debounce_ms, 1 ready_delay_ms), 16-bit data
//
// an item is evaluated by all lanes in the cycle it is accepted
// results leave one per cycle while m_axis accepts them: max(1, changed channels) words per item
// the result serializer sets the rate; a new item is taken while the last
// result of the previous one moves to the output register
// a stalled m_axis holds its word and back-pressures s_axis after one item
// reset clears all channel state, the boot stamp and the registers to defaults
// ----------------------------------------------------------------------------
module multi_channel_input_debouncer_core import dbnc_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // now_ms, pin_levels
  input  logic                   s_axis_tuser,  // action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // channel, level, ready_res, levels, zeros
  output logic                   m_axis_tuser,  // changed
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  logic [CFG_W-1:0]  debounce_q, ready_delay_q;
  logic              boot_done_q;
  logic [TIME_W-1:0] boot_stamp_q;

  logic              accept, boot_ok, lane_en, ready_nxt;
  logic [TIME_W-1:0] now;
  logic [PINS-1:0]   pins, mask, levels;
  lane_res_t         lane_res [CHANNELS];

  assign now    = s_axis_tdata[TIME_W-1:0];
  assign pins   = s_axis_tdata[TIME_W +: PINS];
  assign accept = s_axis_tvalid && s_axis_tready;

  assign boot_ok   = boot_done_q
                     || ((now - boot_stamp_q) >= {{(TIME_W-CFG_W){1'b0}}, ready_delay_q});
  assign lane_en   = accept && (s_axis_tuser == ACT_SAMPLE) && boot_ok;
  assign ready_nxt = boot_done_q || ((s_axis_tuser == ACT_SAMPLE) && boot_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DEBOUNCE_RST;
      ready_delay_q <= READY_DELAY_RST;
      boot_done_q   <= 1'b0;
      boot_stamp_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE:    debounce_q    <= cfg_data_i;
          REG_READY_DELAY: ready_delay_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && (s_axis_tuser == ACT_START)) begin
        boot_stamp_q <= now;
      end
      if (lane_en) begin
        boot_done_q <= 1'b1;
      end
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic raw;
    if (i < PINS) begin : g_pin
      assign raw = pins[i];
    end else begin : g_nopin
      assign raw = 1'b0;
    end
    dbnc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (lane_en),
      .raw_i      (raw),
      .now_i      (now),
      .debounce_i (debounce_q),
      .res_o      (lane_res[i])
    );
  end

  for (genvar i = 0; i < PINS; i++) begin : g_slot
    if (i < CHANNELS) begin : g_used
      assign mask[i]   = lane_res[i].chg;
      assign levels[i] = lane_res[i].lvl_nxt;
    end else begin : g_unused
      assign mask[i]   = 1'b0;
      assign levels[i] = 1'b0;
    end
  end

  dbnc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .mask_i        (mask),
    .levels_i      (levels),
    .ready_i       (ready_nxt),
    .free_o        (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: sv/dbnc_lane.sv
// ----------------------------------------------------------------------------
// dbnc_lane
// one debounce channel: raw history, restart stamp and debounced level
// ----------------------------------------------------------------------------
module dbnc_lane import dbnc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              raw_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [CFG_W-1:0]  debounce_i,
  output lane_res_t         res_o
);

  logic              stable_q, stable_d;
  logic              prev_q;
  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic [TIME_W-1:0] elapsed;
  logic              chg;

  // a restart this item (raw differs from the previous raw) blocks a change through the raw_i == prev_q term
  assign elapsed  = now_i - stamp_q;
  assign chg      = en_i && (raw_i == prev_q) && (raw_i != stable_q)
                    && (elapsed > {{(TIME_W-CFG_W){1'b0}}, debounce_i});
  assign stable_d = chg ? raw_i : stable_q;
  assign stamp_d  = (raw_i != prev_q) ? now_i : stamp_q;

  assign res_o.chg     = chg;
  assign res_o.lvl_nxt = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      prev_q   <= 1'b0;
      stamp_q  <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      prev_q   <= raw_i;
      stamp_q  <= stamp_d;
    end
  end

endmodule

// File: sv/dbnc_merge.sv
// ----------------------------------------------------------------------------
// dbnc_merge
// turns the lanes' change mask into one result word per changed channel, or one no-change word
// ----------------------------------------------------------------------------
module dbnc_merge import dbnc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [PINS-1:0]        mask_i,
  input  logic [PINS-1:0]        levels_i,
  input  logic                   ready_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // channel, level, ready_res, levels, zeros
  output logic                   m_axis_tuser,  // changed
  output logic                   m_axis_tlast
);

  logic                pend_vld_q;
  logic [PINS-1:0]     pend_mask_q;
  logic [PINS-1:0]     pend_lvl_q;
  logic                pend_rdy_q;
  logic                out_vld_q;
  logic [CH_IDX_W-1:0] out_ch_q;
  logic                out_chg_q, out_lvl_q, out_rdy_q, out_last_q;
  logic [PINS-1:0]     out_levels_q;

  logic                out_free, move, last;
  logic [CH_IDX_W-1:0] low_idx;
  logic [PINS-1:0]     rest;

  always_comb begin
    low_idx = '0;
    for (int i = PINS - 1; i >= 0; i--) begin
      if (pend_mask_q[i]) begin
        low_idx = CH_IDX_W'(i);
      end
    end
  end

  assign rest     = pend_mask_q & (pend_mask_q - PINS'(1));
  assign last     = (rest == '0);
  assign out_free = !out_vld_q || m_axis_tready;
  assign move     = pend_vld_q && out_free;
  assign free_o   = !pend_vld_q || (move && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (load_i) begin
        pend_vld_q <= 1'b1;
      end else if (move && last) begin
        pend_vld_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pend_mask_q <= mask_i;
      pend_lvl_q  <= levels_i;
      pend_rdy_q  <= ready_i;
    end else if (move) begin
      pend_mask_q <= rest;
    end
    if (move) begin
      out_chg_q    <= (pend_mask_q != '0);
      out_ch_q     <= low_idx;
      out_lvl_q    <= (pend_mask_q != '0) && pend_lvl_q[low_idx];
      out_rdy_q    <= pend_rdy_q;
      out_levels_q <= pend_lvl_q;
      out_last_q   <= last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_chg_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-PINS-CH_IDX_W-2){1'b0}},
                          out_levels_q, out_rdy_q, out_lvl_q, out_ch_q};

endmodule

// File: sv/dbnc_checker.sv
// ----------------------------------------------------------------------------
// dbnc_checker
// port-level checks of the debouncer, bound to the top level
// ----------------------------------------------------------------------------
module dbnc_checker import dbnc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  logic seen_ready_q;
  logic [PINS-1:0] shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_ready_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[4]) begin
      seen_ready_q <= 1'b1;
    end
  end

  assign shifted = m_axis_tdata[12:5] >> m_axis_tdata[2:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_nochg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[3:0] == 4'd0))
    else $error("no-change word malformed");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[3] == shifted[0]))
    else $error("reported level disagrees with debounced levels");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && seen_ready_q |-> m_axis_tdata[4])
    else $error("ready flag dropped after boot");

endmodule

bind multi_channel_input_debouncer_core dbnc_checker u_dbnc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the eight-channel timestamp debouncer: sample and
// start words go in on s_axis, change words come back on m_axis and are
// compared against a cycle-free model of the channel timers, with random
// gaps on both sides, a long output stall and several debounce settings
// ----------------------------------------------------------------------------
module tb;
  import dbnc_pkg::*;

  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic       changed;
    logic [2:0] pad;
    logic [2:0] chan;
    logic       level;
    logic       ready;
    logic [7:0] levels;
    logic       last;
  } change_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // now_ms, pin_levels
  logic                   s_axis_tuser = 1'b0; // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // channel, level, ready_res, levels, zeros
  logic                   m_axis_tuser;        // changed
  logic                   m_axis_tlast;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int mismatch_cnt = 0;

  // channel timer model
  logic [CFG_W-1:0]    debounce_ms_q = DEBOUNCE_RST;
  logic [CFG_W-1:0]    holdoff_ms_q = READY_DELAY_RST;
  logic [PINS-1:0]     stable_q = '0;
  logic [PINS-1:0]     raw_prev_q = '0;
  logic [TIME_W-1:0]   restart_q [PINS];
  logic                booted_q = 1'b0;
  logic [TIME_W-1:0]   boot_time_q = '0;
  change_word_t        exp_changes[$];

  logic [TIME_W-1:0]   rnd_now = '0;
  logic [PINS-1:0]     rnd_pins = '0;

  multi_channel_input_debouncer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic predict_debounce(input logic act, input logic [TIME_W-1:0] now,
                                  input logic [PINS-1:0] pins);
    change_word_t     res [PINS];
    int               n;
    logic [TIME_W-1:0] dt;
    logic [PINS-1:0]  hit;
    n = 0;
    hit = '0;
    if (act == ACT_START) begin
      boot_time_q = now;
    end else begin
      dt = now - boot_time_q;
      if (!booted_q && dt >= {16'd0, holdoff_ms_q}) booted_q = 1'b1;
      if (booted_q) begin
        for (int i = 0; i < PINS; i++) begin
          if (pins[i] != raw_prev_q[i]) restart_q[i] = now;
          dt = now - restart_q[i];
          if (dt > {16'd0, debounce_ms_q} && pins[i] != stable_q[i]) begin
            stable_q[i] = pins[i];
            hit[i] = 1'b1;
          end
          raw_prev_q[i] = pins[i];
        end
      end
    end
    for (int i = 0; i < PINS; i++) begin
      if (hit[i]) begin
        res[n] = '{changed: 1'b1, pad: 3'd0, chan: 3'(i), level: stable_q[i],
                   ready: booted_q, levels: stable_q, last: 1'b0};
        n++;
      end
    end
    if (n == 0) begin
      res[0] = '{changed: 1'b0, pad: 3'd0, chan: 3'd0, level: 1'b0,
                 ready: booted_q, levels: stable_q, last: 1'b0};
      n = 1;
    end
    res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) exp_changes.push_back(res[i]);
  endtask

  task automatic note_mismatch(input string what, input change_word_t want,
                               input change_word_t got);
    if (mismatch_cnt < 10) begin
      $write("%0t %s: exp chg=%b ch=%0d lvl=%b rdy=%b lv=%h pad=%h last=%b",
             $realtime, what, want.changed, want.chan, want.level, want.ready,
             want.levels, want.pad, want.last);
      $display(" | got chg=%b ch=%0d lvl=%b rdy=%b lv=%h pad=%h last=%b",
               got.changed, got.chan, got.level, got.ready, got.levels, got.pad,
               got.last);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : check_changes
    change_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[15:13], m_axis_tdata[2:0], m_axis_tdata[3],
             m_axis_tdata[4], m_axis_tdata[12:5], m_axis_tlast};
      if (exp_changes.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = exp_changes.pop_front();
        if (got !== want) note_mismatch("mismatch", want, got);
      end
    end
  end

  task automatic send_word(input logic act, input logic [TIME_W-1:0] now,
                           input logic [PINS-1:0] pins);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {pins, now};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_debounce(act, now, pins);
    @(negedge clk_i);
  endtask

  task automatic sample(input logic [TIME_W-1:0] now, input logic [PINS-1:0] pins);
    send_word(ACT_SAMPLE, now, pins);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (exp_changes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_DEBOUNCE:    debounce_ms_q = val;
      REG_READY_DELAY: holdoff_ms_q = val;
      default: ;
    endcase
  endtask

  // boot hold-off across the time wrap, then the default debounce window
  task automatic test_boot_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_reg(REG_READY_DELAY, 16'hFFFF);
    sample(32'd5, 8'hFF);
    send_word(ACT_START, 32'hFFFF_8000, 8'hAA);
    sample(32'h0000_7FFE, 8'hFF);
    sample(32'h0000_7FFF, 8'hFF);
    send_word(ACT_START, 32'h1234_5678, 8'h00);
    sample(32'h0000_7FFF + 32'd50, 8'hFF);
    sample(32'h0000_7FFF + 32'd51, 8'hFF);
    wait_drain();
  endtask

  // zero and full-scale debounce windows, bounces, wrapped channel timers
  task automatic test_debounce_limits();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_READY_DELAY, 16'd0);
    sample(32'h0000_9000, 8'h0F);
    sample(32'h0000_9000, 8'h0F);
    sample(32'h0000_9001, 8'h0F);
    sample(32'h0000_9002, 8'h0E);
    sample(32'h0000_9002, 8'h0F);
    sample(32'h0000_9003, 8'h0F);
    wait_drain();
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    sample(32'hFFFF_FF00, 8'h8F);
    sample(32'hFFFF_FFFF, 8'h8F);
    sample(32'h0000_FEFF, 8'h8F);
    sample(32'h0000_FF00, 8'h8F);
    send_word(ACT_START, 32'hFFFF_FFFF, 8'hFF);
    sample(32'h0000_FF01, 8'h00);
    wait_drain();
    rnd_now  = 32'h0000_FF01;
    rnd_pins = 8'h00;
  endtask

  task automatic random_item(input int step_max);
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_word(ACT_START, $urandom, 8'($urandom));
    end else begin
      if (pick < 12) rnd_now = $urandom;
      else rnd_now += $urandom_range(step_max);
      case ($urandom_range(5))
        0, 1: rnd_pins ^= 8'(1 << $urandom_range(7));
        2:    rnd_pins = 8'($urandom);
        default: ;
      endcase
      sample(rnd_now, rnd_pins);
    end
  endtask

  // output held off long enough that the input side has to stall
  task automatic test_output_stall();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_reg(REG_DEBOUNCE, 16'd3);
    rx_hold_left = 300;
    repeat (30) random_item(8);
    wait_drain();
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct,
                             input logic [CFG_W-1:0] window, input int n_items);
    int step_max;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    write_reg(REG_DEBOUNCE, window);
    write_reg(REG_READY_DELAY, 16'($urandom));
    step_max = int'(window) + int'(window) / 2 + 2;
    repeat (n_items) random_item(step_max);
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < PINS; i++) restart_q[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_boot_holdoff();
    test_debounce_limits();
    test_output_stall();
    test_random(0, 0, 16'($urandom_range(30)), 33);
    test_random(57, 0, DEBOUNCE_RST, 33);
    test_random(0, 57, 16'hFFFF, 33);
    test_random(26, 26, 16'($urandom_range(1, 300)), 33);
    if (mismatch_cnt == 0 && exp_changes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
